// File: hdl/indexed_list_insert_delete_defines.svh
// ----------------------------------------------------------------------------
// indexed list assertion macros
// ----------------------------------------------------------------------------
`ifndef INDEXED_LIST_INSERT_DELETE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_DEFINES_SVH

// checked only outside reset
`define ILID_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ILID_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: hdl/ilid_pkg.sv
// ----------------------------------------------------------------------------
// ilid_pkg
// shared types and constants of the indexed list block
// ----------------------------------------------------------------------------
package ilid_pkg;

    localparam int DATA_W       = 32;
    localparam int CMD_W        = 3;
    localparam int POS_W        = 8;
    localparam int STAT_W       = 2;
    localparam int IN_TDATA_W   = 48;
    localparam int CAPACITY_DEF = 64;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ      = 3'd0,
        CMD_INS_HEAD  = 3'd1,
        CMD_INS_TAIL  = 3'd2,
        CMD_INS_AT    = 3'd3,
        CMD_DELETE    = 3'd4
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // broadcast to every cell
    typedef struct packed {
        logic ins;
        logic del;
        logic rd;
    } t_cell_ctl;

endpackage

// File: hdl/ilid_cell.sv
// ----------------------------------------------------------------------------
// ilid_cell
// one list slot: shifts up on insert, down on delete, drives its value on read
// ----------------------------------------------------------------------------
module ilid_cell #(
    parameter int IDX = 0,
    parameter int PW  = 7
) (
    input  logic                        i_clk,
    input  ilid_pkg::t_cell_ctl         i_ctl,
    input  logic [PW-1:0]               i_pos,
    input  logic [ilid_pkg::DATA_W-1:0] i_value,
    input  logic [ilid_pkg::DATA_W-1:0] i_left,
    input  logic [ilid_pkg::DATA_W-1:0] i_right,
    output logic [ilid_pkg::DATA_W-1:0] o_val,
    output logic [ilid_pkg::DATA_W-1:0] o_rd
);

    localparam logic [PW-1:0] MY_IDX = PW'(IDX);

    logic [ilid_pkg::DATA_W-1:0] r_val;
    logic [ilid_pkg::DATA_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.ins) begin
            if (MY_IDX > i_pos) begin
                n_val = i_left;
            end else if (MY_IDX == i_pos) begin
                n_val = i_value;
            end
        end else if (i_ctl.del && (MY_IDX >= i_pos)) begin
            n_val = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    assign o_rd  = (i_ctl.rd && (MY_IDX == i_pos)) ? r_val : '0;

endmodule

// File: hdl/indexed_list_insert_delete.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_delete
// a result is registered by the same clock edge that accepts its request
// throughput: one request per cycle while the output is not stalled; all cells shift in parallel
// a stalled result holds the request side only until the output is taken
// reset (synchronous, active low) empties the list and drops the output valid
// ----------------------------------------------------------------------------
`include "indexed_list_insert_delete_defines.svh"

module indexed_list_insert_delete #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // command[2:0], position[10:3], value[42:11], zero fill above
    input  logic [ilid_pkg::IN_TDATA_W-1:0] i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // read_value[31:0], status[33:32], length above, zero fill to a byte
    output logic [((ilid_pkg::DATA_W + ilid_pkg::STAT_W + $clog2(CAPACITY + 1) + 7) / 8) * 8 - 1:0]
                                            o_m_tdata
);

    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int PW    = (CW > ilid_pkg::POS_W - 1) ? CW : ilid_pkg::POS_W - 1;
    localparam int OUT_W = ((ilid_pkg::DATA_W + ilid_pkg::STAT_W + CW + 7) / 8) * 8;
    localparam int DW    = ilid_pkg::DATA_W;

    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic             r_out_valid;
    logic [OUT_W-1:0] r_out_data;

    logic                    s_acc;
    ilid_pkg::t_cmd          cmd;
    logic [ilid_pkg::POS_W-1:0] pos_raw;
    logic [DW-1:0]           value;
    logic                    neg;
    logic [PW-1:0]           pos_ext;
    logic [PW-1:0]           cnt_ext;
    logic [PW-1:0]           ins_pos;
    logic [PW-1:0]           cell_pos;
    logic                    in_range;
    logic                    full;
    logic                    do_ins;
    logic                    do_del;
    logic                    do_rd;
    ilid_pkg::t_status       status;
    logic [DW-1:0]           read_value;
    logic [DW-1:0]           rd_or;
    ilid_pkg::t_cell_ctl     ctl;

    logic [DW-1:0] cell_val [CAPACITY];
    logic [DW-1:0] cell_rd  [CAPACITY];

    assign s_acc      = i_s_tvalid && o_s_tready;
    assign o_s_tready = !r_out_valid || i_m_tready;

    assign cmd     = ilid_pkg::t_cmd'(i_s_tdata[2:0]);
    assign pos_raw = i_s_tdata[10:3];
    assign value   = i_s_tdata[42:11];

    assign neg      = pos_raw[ilid_pkg::POS_W-1];
    assign pos_ext  = PW'(pos_raw[ilid_pkg::POS_W-2:0]);
    assign cnt_ext  = PW'(r_count);
    assign in_range = !neg && (pos_ext < cnt_ext);
    assign full     = (r_count == CW'(CAPACITY));

    // decode: range check comes before the full check on inserts
    always_comb begin
        do_ins     = 1'b0;
        do_del     = 1'b0;
        do_rd      = 1'b0;
        status     = ilid_pkg::ST_DONE;
        read_value = '0;
        ins_pos    = '0;
        case (cmd)
            ilid_pkg::CMD_READ: begin
                do_rd = 1'b1;
                if (in_range) begin
                    read_value = rd_or;
                end else begin
                    read_value = '1;
                    status     = ilid_pkg::ST_RANGE;
                end
            end
            ilid_pkg::CMD_INS_HEAD, ilid_pkg::CMD_INS_TAIL, ilid_pkg::CMD_INS_AT: begin
                if (cmd == ilid_pkg::CMD_INS_TAIL) begin
                    ins_pos = cnt_ext;
                end else if (cmd == ilid_pkg::CMD_INS_AT && !neg) begin
                    ins_pos = pos_ext;
                end
                if (ins_pos > cnt_ext) begin
                    status = ilid_pkg::ST_RANGE;
                end else if (full) begin
                    status = ilid_pkg::ST_FULL;
                end else begin
                    do_ins = 1'b1;
                end
            end
            ilid_pkg::CMD_DELETE: begin
                if (in_range) begin
                    do_del = 1'b1;
                end else begin
                    status = ilid_pkg::ST_RANGE;
                end
            end
            default: begin
            end
        endcase
    end

    assign ctl.ins  = s_acc && do_ins;
    assign ctl.del  = s_acc && do_del;
    assign ctl.rd   = do_rd;
    assign cell_pos = do_ins ? ins_pos : pos_ext;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DW-1:0] left;
            logic [DW-1:0] right;
            if (gi == 0) begin : g_first
                assign left = value;
            end else begin : g_mid_l
                assign left = cell_val[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign right = cell_val[gi];
            end else begin : g_mid_r
                assign right = cell_val[gi+1];
            end
            ilid_cell #(
                .IDX (gi),
                .PW  (PW)
            ) u_cell (
                .i_clk   (i_clk),
                .i_ctl   (ctl),
                .i_pos   (cell_pos),
                .i_value (value),
                .i_left  (left),
                .i_right (right),
                .o_val   (cell_val[gi]),
                .o_rd    (cell_rd[gi])
            );
        end
    endgenerate

    // only the addressed cell drives a nonzero read word
    always_comb begin
        rd_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            rd_or = rd_or | cell_rd[k];
        end
    end

    always_comb begin
        n_count = r_count;
        if (ctl.ins) begin
            n_count = r_count + CW'(1);
        end else if (ctl.del) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_acc) begin
                r_count <= n_count;
            end
            if (o_s_tready) begin
                r_out_valid <= i_s_tvalid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_out_data <= OUT_W'({n_count, status, read_value});
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `ILID_ASSERT(a_count_bound, r_count <= CW'(CAPACITY), "entry count above capacity")
    `ILID_ASSERT(a_refused_keeps, s_acc && status != ilid_pkg::ST_DONE |=> $stable(r_count), "refused request changed the list length")
    `ILID_ASSERT(a_len_matches, s_acc |=> r_out_data[DW+ilid_pkg::STAT_W +: CW] == r_count, "reported length differs from entry count")
    `ILID_ASSERT_ALWAYS(a_reset_clear, !i_rst_n |=> r_count == '0 && !r_out_valid, "reset did not empty the list")

endmodule

// File: tb/sv/indexed_list_insert_delete_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_checker
// watches both stream channels of the indexed list, keeps its own copy of the
// list, predicts the result of every accepted request and compares each
// accepted result field by field against the oldest prediction
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_checker #(
    parameter int CAPACITY = ilid_pkg::CAPACITY_DEF,
    parameter int LEN_W    = $clog2(CAPACITY + 1),
    parameter int OUT_W    = ((ilid_pkg::DATA_W + ilid_pkg::STAT_W + LEN_W + 7) / 8) * 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    // command[2:0], position[10:3], value[42:11], zero fill above
    input  logic [ilid_pkg::IN_TDATA_W-1:0] i_s_tdata,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    // read_value[31:0], status[33:32], length above, zero fill to a byte
    input  logic [OUT_W-1:0]                i_m_tdata,
    output int                              o_fail_count,
    output int                              o_outstanding,
    output int                              o_list_length
);

    typedef struct packed {
        logic [ilid_pkg::DATA_W-1:0] read_value;
        ilid_pkg::t_status           status;
        logic [LEN_W-1:0]            length;
    } t_list_result;

    logic [ilid_pkg::DATA_W-1:0] cells [CAPACITY];
    int                          cell_count;
    int                          fail_total;
    t_list_result                predicted_results [$];
    t_list_result                oldest;

    initial begin
        cell_count = 0;
        fail_total = 0;
    end

    // applies one command to the local list and returns what the block owes
    function automatic t_list_result apply_command(
        input logic [ilid_pkg::CMD_W-1:0]        cmd,
        input logic signed [ilid_pkg::POS_W-1:0] pos,
        input logic [ilid_pkg::DATA_W-1:0]       val
    );
        t_list_result r;
        int           p;
        int           i;
        r.read_value = '0;
        r.status     = ilid_pkg::ST_DONE;
        case (cmd)
            ilid_pkg::CMD_READ: begin
                if (pos < 0 || int'(pos) >= cell_count) begin
                    r.read_value = '1;
                    r.status     = ilid_pkg::ST_RANGE;
                end else begin
                    r.read_value = cells[int'(pos)];
                end
            end
            ilid_pkg::CMD_INS_HEAD, ilid_pkg::CMD_INS_TAIL, ilid_pkg::CMD_INS_AT: begin
                if (cmd == ilid_pkg::CMD_INS_HEAD) begin
                    p = 0;
                end else if (cmd == ilid_pkg::CMD_INS_TAIL) begin
                    p = cell_count;
                end else begin
                    p = (pos < 0) ? 0 : int'(pos);
                end
                // range is checked ahead of full
                if (p > cell_count) begin
                    r.status = ilid_pkg::ST_RANGE;
                end else if (cell_count >= CAPACITY) begin
                    r.status = ilid_pkg::ST_FULL;
                end else begin
                    for (i = cell_count; i > p; i--) cells[i] = cells[i-1];
                    cells[p] = val;
                    cell_count++;
                end
            end
            ilid_pkg::CMD_DELETE: begin
                if (pos < 0 || int'(pos) >= cell_count) begin
                    r.status = ilid_pkg::ST_RANGE;
                end else begin
                    for (i = int'(pos); i + 1 < cell_count; i++) cells[i] = cells[i+1];
                    cell_count--;
                end
            end
            default: ;
        endcase
        r.length = LEN_W'(cell_count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cell_count = 0;
            predicted_results.delete();
        end else begin
            // result side first: a request taken at this edge cannot be answered yet
            if (i_m_tvalid && i_m_tready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got %h",
                             $time, i_m_tdata);
                    fail_total++;
                end else begin
                    oldest = predicted_results.pop_front();
                    if (i_m_tdata[ilid_pkg::DATA_W-1:0] !== oldest.read_value) begin
                        $display("%0t: read_value mismatch, expected %h, got %h",
                                 $time, oldest.read_value,
                                 i_m_tdata[ilid_pkg::DATA_W-1:0]);
                        fail_total++;
                    end
                    if (i_m_tdata[ilid_pkg::DATA_W +: ilid_pkg::STAT_W] !== oldest.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, oldest.status,
                                 i_m_tdata[ilid_pkg::DATA_W +: ilid_pkg::STAT_W]);
                        fail_total++;
                    end
                    if (i_m_tdata[ilid_pkg::DATA_W + ilid_pkg::STAT_W +: LEN_W]
                            !== oldest.length) begin
                        $display("%0t: length mismatch, expected %0d, got %0d",
                                 $time, oldest.length,
                                 i_m_tdata[ilid_pkg::DATA_W + ilid_pkg::STAT_W +: LEN_W]);
                        fail_total++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                predicted_results.push_back(apply_command(i_s_tdata[2:0],
                                                          i_s_tdata[10:3],
                                                          i_s_tdata[42:11]));
            end
        end
        o_fail_count  <= fail_total;
        o_outstanding <= predicted_results.size();
        o_list_length <= cell_count;
    end

endmodule

// File: tb/sv/indexed_list_insert_delete_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_list_insert_delete_tb
// drives directed and phased random list commands into the indexed list with
// random gaps and stalls on both channels, one long result stall included,
// and reports the verdict from the checker's failure count
// ----------------------------------------------------------------------------
module indexed_list_insert_delete_tb;

    localparam int CAPACITY          = ilid_pkg::CAPACITY_DEF;
    localparam int LEN_W             = $clog2(CAPACITY + 1);
    localparam int OUT_W             =
        ((ilid_pkg::DATA_W + ilid_pkg::STAT_W + LEN_W + 7) / 8) * 8;
    localparam int HALF_PERIOD       = 6;
    localparam int RESET_CYCLES      = 6;
    localparam int STALL_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES      = 4;
    localparam int LIMIT_CYCLES      = 400000;
    localparam int STALL_AT_ITEM     = 130;

    // command codes the block leaves unused
    localparam logic [ilid_pkg::CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
    localparam logic [ilid_pkg::CMD_W-1:0] CMD_SPARE_MID   = 3'd6;
    localparam logic [ilid_pkg::CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

    typedef enum int {
        PH_FILL,
        PH_MIX,
        PH_DRAIN
    } t_mix_phase;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_s_tvalid;
    logic                            o_s_tready;
    logic [ilid_pkg::IN_TDATA_W-1:0] i_s_tdata;
    logic                            o_m_tvalid;
    logic                            i_m_tready;
    logic [OUT_W-1:0]                o_m_tdata;

    int fail_count;
    int outstanding;
    int list_length;

    bit steady_mode;
    bit stall_request;
    bit stall_done;

    indexed_list_insert_delete #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata)
    );

    indexed_list_insert_delete_checker #(
        .CAPACITY(CAPACITY)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .o_fail_count (fail_count),
        .o_outstanding(outstanding),
        .o_list_length(list_length)
    );

    initial i_clk = 1'b0;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    initial begin
        #(LIMIT_CYCLES * 2 * HALF_PERIOD);
        $display("indexed_list_insert_delete_tb: errors");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_mode || r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // called right after a falling edge, returns right after one
    task automatic send_request(
        input logic [ilid_pkg::CMD_W-1:0]        cmd,
        input logic signed [ilid_pkg::POS_W-1:0] pos,
        input logic [ilid_pkg::DATA_W-1:0]       val
    );
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, val, pos, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
    endtask

    task automatic send_random(input t_mix_phase phase);
        int                                r;
        logic [ilid_pkg::CMD_W-1:0]        cmd;
        logic signed [ilid_pkg::POS_W-1:0] pos;
        r = $urandom_range(0, 99);
        case (phase)
            PH_FILL: begin
                if (r < 30)      cmd = ilid_pkg::CMD_INS_HEAD;
                else if (r < 55) cmd = ilid_pkg::CMD_INS_TAIL;
                else if (r < 85) cmd = ilid_pkg::CMD_INS_AT;
                else if (r < 92) cmd = ilid_pkg::CMD_READ;
                else if (r < 96) cmd = ilid_pkg::CMD_DELETE;
                else             cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
            PH_MIX: begin
                if (r < 20)      cmd = ilid_pkg::CMD_READ;
                else if (r < 35) cmd = ilid_pkg::CMD_INS_HEAD;
                else if (r < 50) cmd = ilid_pkg::CMD_INS_TAIL;
                else if (r < 70) cmd = ilid_pkg::CMD_INS_AT;
                else if (r < 95) cmd = ilid_pkg::CMD_DELETE;
                else             cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
            default: begin
                if (r < 20)      cmd = ilid_pkg::CMD_READ;
                else if (r < 25) cmd = ilid_pkg::CMD_INS_HEAD;
                else if (r < 30) cmd = ilid_pkg::CMD_INS_AT;
                else if (r < 95) cmd = ilid_pkg::CMD_DELETE;
                else             cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
            end
        endcase
        // mostly positions in or just past the list, sometimes any byte
        if ($urandom_range(0, 9) < 7) pos = ilid_pkg::POS_W'($urandom_range(0, list_length));
        else                          pos = ilid_pkg::POS_W'($urandom);
        send_request(cmd, pos, $urandom);
    endtask

    // result side: random stalls plus one long hold-off on request
    initial begin
        int burst;
        int gap;
        i_m_tready = 1'b0;
        stall_done = 1'b0;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (stall_request && !stall_done) begin
                i_m_tready <= 1'b0;
                stall_done = 1'b1;
                repeat (STALL_HOLD_CYCLES) @(negedge i_clk);
            end else if (steady_mode) begin
                i_m_tready <= 1'b1;
                @(negedge i_clk);
            end else begin
                burst = $urandom_range(1, 6);
                i_m_tready <= 1'b1;
                repeat (burst) @(negedge i_clk);
                gap = pick_gap();
                if (gap > 0) begin
                    i_m_tready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
        end
    end

    initial begin
        int         n;
        t_mix_phase phase;
        i_rst_n       = 1'b0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        steady_mode   = 1'b0;
        stall_request = 1'b0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // empty list edge cases, head/tail/append paths and out of range positions
        send_request(ilid_pkg::CMD_READ,     8'sd0,    32'h0000_0001);
        send_request(ilid_pkg::CMD_DELETE,   8'sd0,    32'h0000_0002);
        send_request(ilid_pkg::CMD_INS_AT,   8'sd1,    32'h1234_5678);
        send_request(ilid_pkg::CMD_INS_AT,   -8'sd128, 32'h8000_0000);
        send_request(ilid_pkg::CMD_INS_HEAD, 8'sd0,    32'h7fff_ffff);
        send_request(ilid_pkg::CMD_INS_TAIL, 8'sd127,  32'hffff_ffff);
        send_request(ilid_pkg::CMD_INS_AT,   8'sd3,    32'h0000_0000);
        send_request(ilid_pkg::CMD_INS_AT,   8'sd127,  32'hdead_beef);
        send_request(ilid_pkg::CMD_INS_AT,   -8'sd1,   32'h5555_5555);
        send_request(ilid_pkg::CMD_INS_AT,   8'sd2,    32'haaaa_aaaa);
        send_request(ilid_pkg::CMD_READ,     8'sd0,    32'h0);
        send_request(ilid_pkg::CMD_READ,     8'sd5,    32'h0);
        send_request(ilid_pkg::CMD_READ,     8'sd6,    32'h0);
        send_request(ilid_pkg::CMD_READ,     -8'sd1,   32'h0);
        send_request(ilid_pkg::CMD_READ,     8'sd127,  32'h0);
        send_request(ilid_pkg::CMD_READ,     -8'sd128, 32'h0);
        send_request(ilid_pkg::CMD_DELETE,   -8'sd128, 32'h0);
        send_request(ilid_pkg::CMD_DELETE,   8'sd127,  32'h0);
        send_request(ilid_pkg::CMD_DELETE,   8'sd6,    32'h0);
        send_request(ilid_pkg::CMD_DELETE,   8'sd2,    32'h0);
        send_request(ilid_pkg::CMD_DELETE,   8'sd0,    32'h0);
        send_request(CMD_SPARE_FIRST,        8'sd0,    32'hffff_ffff);
        send_request(CMD_SPARE_MID,          -8'sd1,   32'h0f0f_0f0f);
        send_request(CMD_SPARE_LAST,         8'sd127,  32'hf0f0_f0f0);
        send_request(ilid_pkg::CMD_READ,     8'sd3,    32'h0);

        // fill to capacity, churn, drain, then again
        for (n = 0; n < 450; n++) begin
            if (n < 110)      phase = PH_FILL;
            else if (n < 210) phase = PH_MIX;
            else if (n < 320) phase = PH_DRAIN;
            else if (n < 400) phase = PH_FILL;
            else              phase = PH_MIX;
            steady_mode = (n % 100) < 20;
            if (n == STALL_AT_ITEM) stall_request = 1'b1;
            send_random(phase);
        end
        i_s_tvalid  <= 1'b0;
        steady_mode = 1'b0;

        while (outstanding != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("indexed_list_insert_delete_tb: clean");
        end else begin
            $display("indexed_list_insert_delete_tb: errors");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+hdl
hdl/ilid_pkg.sv
hdl/ilid_cell.sv
hdl/indexed_list_insert_delete.sv
tb/sv/indexed_list_insert_delete_checker.sv
tb/sv/indexed_list_insert_delete_tb.sv
